// ===== hw/rtl/rcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and types for the red-mean colour distance block.
// No dependencies; every other file in hw/rtl uses this package.

package rcd_pkg;

  // Fraction bits of the distance result (range 0..4)
  localparam int FRAC_BITS = 4;

  localparam int CH_W   = 8;
  localparam int SUM_W  = 20;
  localparam int DIST_W = 14;
  localparam int SQ_W   = 2 * CH_W;
  localparam int WT_W   = 10;
  localparam int PROD_W = WT_W + SQ_W;

  // Radicand is the sum shifted left by 2*FRAC_BITS bits; the root has half its bits
  localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;

  // Decoupling queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [WT_W-1:0] RED_BASE  = 10'd512;
  localparam logic [WT_W-1:0] BLUE_BASE = 10'd767;

  // Front to queue: input accepted this cycle, finished sum to push
  typedef struct packed {
    logic             accept;
    logic             push;
    logic [SUM_W-1:0] sum;
  } front_q_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } q_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the colour pair input and the distance result.
// Depends on rcd_pkg for field widths.

interface rcd_pair_if;
  logic                     valid;
  logic                     ready;
  logic [rcd_pkg::CH_W-1:0] first_red;
  logic [rcd_pkg::CH_W-1:0] first_green;
  logic [rcd_pkg::CH_W-1:0] first_blue;
  logic [rcd_pkg::CH_W-1:0] second_red;
  logic [rcd_pkg::CH_W-1:0] second_green;
  logic [rcd_pkg::CH_W-1:0] second_blue;

  modport source (
    output valid, first_red, first_green, first_blue,
    output second_red, second_green, second_blue,
    input  ready
  );
  modport sink (
    input  valid, first_red, first_green, first_blue,
    input  second_red, second_green, second_blue,
    output ready
  );
endinterface

interface rcd_dist_if;
  logic                       valid;
  logic                       ready;
  logic [rcd_pkg::SUM_W-1:0]  weighted_square_sum;
  logic [rcd_pkg::DIST_W-1:0] distance_fixed;

  modport source (output valid, weighted_square_sum, distance_fixed, input ready);
  modport sink (input valid, weighted_square_sum, distance_fixed, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rcd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts colour pairs and forms the weighted square sum in four stages.
// Depends on rcd_pkg and rcd_ifs; free-running, admission is gated by queue credit.

module rcd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  rcd_pair_if.sink               pair,
  input  wire logic              room,
  output rcd_pkg::front_q_t      fq
);

  function automatic logic [rcd_pkg::CH_W-1:0] abs_diff(
    input logic [rcd_pkg::CH_W-1:0] a,
    input logic [rcd_pkg::CH_W-1:0] b
  );
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  logic accept;

  logic                        v1, v2, v3, v4;
  logic [rcd_pkg::CH_W-1:0]    mean1, dr1, dg1, db1;
  logic [rcd_pkg::SQ_W-1:0]    dr2, dg2, db2;
  logic [rcd_pkg::WT_W-1:0]    wr2, wb2;
  logic [rcd_pkg::PROD_W-1:0]  pr3, pb3;
  logic [rcd_pkg::SQ_W+1:0]    g3;
  logic [rcd_pkg::SUM_W-1:0]   sum4;

  assign pair.ready = room;
  assign accept     = pair.valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // differences and truncated red mean
    mean1 <= rcd_pkg::CH_W'(({1'b0, pair.first_red} + {1'b0, pair.second_red}) >> 1);
    dr1   <= abs_diff(pair.first_red, pair.second_red);
    dg1   <= abs_diff(pair.first_green, pair.second_green);
    db1   <= abs_diff(pair.first_blue, pair.second_blue);
    // squares and channel weights
    dr2   <= dr1 * dr1;
    dg2   <= dg1 * dg1;
    db2   <= db1 * db1;
    wr2   <= rcd_pkg::RED_BASE + rcd_pkg::WT_W'(mean1);
    wb2   <= rcd_pkg::BLUE_BASE - rcd_pkg::WT_W'(mean1);
    // weighted products
    pr3   <= wr2 * dr2;
    pb3   <= wb2 * db2;
    g3    <= {dg2, 2'b00};
    // scale and add
    sum4  <= rcd_pkg::SUM_W'(pr3 >> 8) + rcd_pkg::SUM_W'(pb3 >> 8) + rcd_pkg::SUM_W'(g3);
  end

  assign fq.accept = accept;
  assign fq.push   = v4;
  assign fq.sum    = sum4;

endmodule

`default_nettype wire

// ===== hw/rtl/rcd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short FIFO between front and back, with credit covering items still in the front.
// Depends on rcd_pkg.

module rcd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  rcd_pkg::front_q_t        fq,
  input  wire logic                pop,
  output logic                     room,
  output rcd_pkg::q_head_t         head
);

  logic [rcd_pkg::SUM_W-1:0]   mem [0:rcd_pkg::Q_DEPTH-1];
  logic [rcd_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [rcd_pkg::Q_CNT_W-1:0] fill, fill_next;
  logic [rcd_pkg::Q_CNT_W-1:0] occ, occ_next;

  // occ counts every accepted item not yet popped, so the FIFO cannot overflow
  assign occ_next  = occ + rcd_pkg::Q_CNT_W'(fq.accept) - rcd_pkg::Q_CNT_W'(pop);
  assign fill_next = fill + rcd_pkg::Q_CNT_W'(fq.push) - rcd_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      occ    <= '0;
    end else begin
      fill <= fill_next;
      occ  <= occ_next;
      if (fq.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fq.push) begin
      mem[wr_ptr] <= fq.sum;
    end
  end

  assign room       = occ < rcd_pkg::Q_CNT_W'(rcd_pkg::Q_DEPTH);
  assign head.valid = fill != '0;
  assign head.sum   = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/rcd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back end: pipelined digit-by-digit square root, one root bit per stage.
// Depends on rcd_pkg and rcd_ifs; the whole pipe holds while the result is stalled.

module rcd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  rcd_pkg::q_head_t       head,
  output logic                   pop,
  rcd_dist_if.source             result
);

  localparam int N = rcd_pkg::ROOT_W;

  logic adv;

  logic                        v_q    [1:N];
  logic [rcd_pkg::SUM_W-1:0]   sum_q  [1:N];
  logic [rcd_pkg::ROOT_W-1:0]  root_q [1:N];
  logic [rcd_pkg::RAD_W-1:0]   x_q    [1:N-1];
  logic [rcd_pkg::ROOT_W-1:0]  rem_q  [1:N-1];

  assign adv = !v_q[N] || result.ready;
  assign pop = adv && head.valid;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        vi;
    logic [rcd_pkg::SUM_W-1:0]   sumi;
    logic [rcd_pkg::ROOT_W-1:0]  rooti;
    logic [rcd_pkg::RAD_W-1:0]   xi;
    logic [rcd_pkg::ROOT_W-1:0]  remi;
    logic [rcd_pkg::ROOT_W+1:0]  rem_sh, trial;
    logic                        ge;

    if (k == 0) begin : g_src
      assign vi    = head.valid;
      assign sumi  = head.sum;
      assign rooti = '0;
      assign xi    = rcd_pkg::RAD_W'(head.sum) << (2 * rcd_pkg::FRAC_BITS);
      assign remi  = '0;
    end else begin : g_src
      assign vi    = v_q[k];
      assign sumi  = sum_q[k];
      assign rooti = root_q[k];
      assign xi    = x_q[k];
      assign remi  = rem_q[k];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {remi, xi[rcd_pkg::RAD_W-1 -: 2]};
    assign trial  = {rooti, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sum_q[k+1]  <= sumi;
        root_q[k+1] <= {rooti[rcd_pkg::ROOT_W-2:0], ge};
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          x_q[k+1]   <= xi << 2;
          rem_q[k+1] <= rcd_pkg::ROOT_W'(ge ? rem_sh - trial : rem_sh);
        end
      end
    end
  end

  assign result.valid               = v_q[N];
  assign result.weighted_square_sum = sum_q[N];
  assign result.distance_fixed      = rcd_pkg::DIST_W'(root_q[N]);

endmodule

`default_nettype wire

// ===== hw/rtl/redmean_color_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Red-mean weighted colour distance.
//
// Input channel pair (rcd_pair_if, sink): two RGB colours, 8 bits a channel.
// Output channel result (rcd_dist_if, source): the weighted square sum and the
// floor of its square root with FRAC_BITS fraction bits. One result beat per
// input beat, in order; a beat moves when valid and ready are both high.
//
// Throughput: one pair per cycle while result.ready stays high.
// Path: 4 front stages, the registered queue, then one square root stage per root
// bit (10 + FRAC_BITS). The root pipeline sets the latency; the front
// multipliers set the depth of the front.
// A stalled result holds the root pipeline; the front keeps running and its
// output collects in an 8-entry queue. pair.ready drops once 8 pairs are
// accepted but not yet taken into the root pipeline.
// Reset (rst, synchronous) empties the queue and all pipeline stages; pair.ready
// is high in the first cycle after reset.

module redmean_color_distance (
  input  wire logic  clk,
  input  wire logic  rst,
  rcd_pair_if.sink   pair,
  rcd_dist_if.source result
);

  rcd_pkg::front_q_t fq;
  rcd_pkg::q_head_t  head;
  logic              room;
  logic              pop;

  rcd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .pair (pair),
    .room (room),
    .fq   (fq)
  );

  rcd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .fq   (fq),
    .pop  (pop),
    .room (room),
    .head (head)
  );

  rcd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  // no result may appear straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // every push into the queue comes from a pair accepted earlier and passed through the front stages
  a_push_origin: assert property (@(posedge clk) disable iff (rst)
    fq.push |-> $past(pair.valid && pair.ready, 4))
    else $error("queue push without matching accepted pair");

  // the back end must not take from the queue while its result is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !pop)
    else $error("queue popped while result stalled");

  // a pop only ever takes a real entry
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
